[rtl/core/tapid_pkg.sv]
// Package for the two-axis tracking PID: field widths, register codes,
// limits and the shared types. Used by every other file of the block.
package tapid_pkg;

   // Field widths
   localparam int OFFSET_W   = 12;
   localparam int GAIN_W     = 10;
   localparam int DEAD_W     = 8;
   localparam int PULSE_W    = 10;
   localparam int SERVO_W    = 5;
   localparam int INTEG_W    = 16;
   localparam int OUT_W      = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Default parameter values
   localparam int INTEGRAL_LIMIT_X_DEF = 100;
   localparam int INTEGRAL_LIMIT_Y_DEF = 60;
   localparam int OUTPUT_LIMIT_X_DEF   = 12;
   localparam int OUTPUT_LIMIT_Y_DEF   = 6;
   localparam int PULSES_PER_TURN_DEF  = 3200;
   localparam int ZERO_PERIOD_DEF      = 50;

   // Fixed constants
   localparam int PULSE_MAX     = 1023;
   localparam int DEG_PER_TURN  = 360;
   localparam int SERVO_LOW     = 0;
   localparam int SERVO_HIGH    = 20;
   localparam int SERVO_CENTER  = 10;
   localparam int SCALE_DIV     = 100;

   // Divide by 100: floor(m * 5243 / 2^19) is exact for m below 43690
   localparam int QUOT_IN_W    = 14;
   localparam int RECIP_W      = 13;
   localparam int RECIP_100    = 5243;
   localparam int RECIP_SHIFT  = 19;

   // Reset values of the registers
   localparam logic [GAIN_W-1:0] GAIN_P_X_RST  = 10'd18;
   localparam logic [GAIN_W-1:0] GAIN_P_Y_RST  = 10'd15;
   localparam logic [DEAD_W-1:0] DEAD_ZONE_RST = 8'd14;

   // Register index codes
   localparam logic [REG_IDX_W-1:0] REG_GAIN_P_X  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_I_X  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_D_X  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_P_Y  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_I_Y  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_D_Y  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE = 3'd6;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p_x;
      logic [GAIN_W-1:0] gain_i_x;
      logic [GAIN_W-1:0] gain_d_x;
      logic [GAIN_W-1:0] gain_p_y;
      logic [GAIN_W-1:0] gain_i_y;
      logic [GAIN_W-1:0] gain_d_y;
      logic [DEAD_W-1:0] dead_zone;
   } tapid_cfg_type;

   // Load enables of the three PID stages
   typedef struct packed {
      logic ld_s2;
      logic ld_s3;
      logic ld_s4;
   } tapid_stage_ctl_type;

   // Pulse count for a move of deg degrees, saturated to the pulse field
   function automatic int pulse_count(int deg, int ppt);
      longint p;
      p = (longint'(deg) * longint'(ppt)) / DEG_PER_TURN;
      if (p > PULSE_MAX) begin
         return PULSE_MAX;
      end
      return int'(p);
   endfunction

endpackage

[rtl/core/tapid_if.sv]
// Request and result channel interfaces of the two-axis tracking PID.
// Depends on tapid_pkg for the field widths.
interface tapid_req_if import tapid_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OFFSET_W-1:0] offset_x;
   logic signed [OFFSET_W-1:0] offset_y;

   modport source (output valid, output offset_x, output offset_y, input ready);
   modport sink   (input valid, input offset_x, input offset_y, output ready);
endinterface

interface tapid_rsp_if import tapid_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               step_enable;
   logic               step_dir;
   logic [PULSE_W-1:0] step_pulses;
   logic [SERVO_W-1:0] servo_setting;
   logic               zero_position;

   modport source (output valid, output step_enable, output step_dir, output step_pulses,
                   output servo_setting, output zero_position, input ready);
   modport sink   (input valid, input step_enable, input step_dir, input step_pulses,
                   input servo_setting, input zero_position, output ready);
endinterface

[rtl/core/tapid_csr.sv]
// APB-style register file holding the PID gains and the dead zone.
// Depends on tapid_pkg for the register codes and the config struct.
module tapid_csr import tapid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output tapid_cfg_type         cfg
);

   tapid_cfg_type          cfg_ff;
   tapid_cfg_type          cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_GAIN_P_X:  cfg_in.gain_p_x  = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_I_X:  cfg_in.gain_i_x  = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_D_X:  cfg_in.gain_d_x  = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_P_Y:  cfg_in.gain_p_y  = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_I_Y:  cfg_in.gain_i_y  = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_D_Y:  cfg_in.gain_d_y  = csr_pwdata[GAIN_W-1:0];
            REG_DEAD_ZONE: cfg_in.dead_zone = csr_pwdata[DEAD_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p_x  <= GAIN_P_X_RST;
         cfg_ff.gain_i_x  <= '0;
         cfg_ff.gain_d_x  <= '0;
         cfg_ff.gain_p_y  <= GAIN_P_Y_RST;
         cfg_ff.gain_i_y  <= '0;
         cfg_ff.gain_d_y  <= '0;
         cfg_ff.dead_zone <= DEAD_ZONE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_GAIN_P_X:  csr_prdata = CSR_DATA_W'(cfg_ff.gain_p_x);
         REG_GAIN_I_X:  csr_prdata = CSR_DATA_W'(cfg_ff.gain_i_x);
         REG_GAIN_D_X:  csr_prdata = CSR_DATA_W'(cfg_ff.gain_d_x);
         REG_GAIN_P_Y:  csr_prdata = CSR_DATA_W'(cfg_ff.gain_p_y);
         REG_GAIN_I_Y:  csr_prdata = CSR_DATA_W'(cfg_ff.gain_i_y);
         REG_GAIN_D_Y:  csr_prdata = CSR_DATA_W'(cfg_ff.gain_d_y);
         REG_DEAD_ZONE: csr_prdata = CSR_DATA_W'(cfg_ff.dead_zone);
         default:       csr_prdata = '0;
      endcase
   end

endmodule

[rtl/core/tapid_axis.sv]
// One PID axis in three stages: error and state update, gain products,
// sum with scale and clamp. Depends on tapid_pkg.
module tapid_axis import tapid_pkg::*; #(
   parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_X_DEF,
   parameter int OUTPUT_LIMIT   = OUTPUT_LIMIT_X_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tapid_stage_ctl_type        ctl,
   input  logic signed [OFFSET_W-1:0] offset,
   input  logic [GAIN_W-1:0]          gain_p,
   input  logic [GAIN_W-1:0]          gain_i,
   input  logic [GAIN_W-1:0]          gain_d,
   input  logic [DEAD_W-1:0]          dead_zone,
   output logic signed [OUT_W-1:0]    axis_out
);

   localparam int MAG_W  = OFFSET_W - 1;
   localparam int DIFF_W = OFFSET_W + 1;
   localparam int ISUM_W = INTEG_W + 1;
   localparam int PP_W   = GAIN_W + 1 + OFFSET_W;
   localparam int DP_W   = GAIN_W + 1 + DIFF_W;
   localparam int IP_W   = GAIN_W + 1 + INTEG_W;
   localparam int SUM_W  = IP_W + 1;
   localparam int QP_W   = QUOT_IN_W + RECIP_W;
   localparam int THRESH = SCALE_DIV * (OUTPUT_LIMIT + 1);

   localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};
   localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
   localparam logic signed [ISUM_W-1:0]   ILIM_POS   = ISUM_W'(INTEGRAL_LIMIT);
   localparam logic signed [ISUM_W-1:0]   ILIM_NEG   = -ISUM_W'(INTEGRAL_LIMIT);
   localparam logic [SUM_W-1:0]           THRESH_V   = SUM_W'(THRESH);
   localparam logic [OUT_W-1:0]           OLIM_V     = OUT_W'(OUTPUT_LIMIT);
   localparam logic [RECIP_W-1:0]         RECIP_V    = RECIP_W'(RECIP_100);

   // Controller state
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [OFFSET_W-1:0] last_ff, last_in;

   // Stage 2 registers
   logic signed [OFFSET_W-1:0] e_s2_ff;
   logic signed [DIFF_W-1:0]   diff_s2_ff;
   logic signed [INTEG_W-1:0]  integ_s2_ff;
   logic                       use_d_s2_ff, use_i_s2_ff, dead_s2_ff;

   // Stage 3 registers
   logic signed [PP_W-1:0] pp_s3_ff;
   logic signed [DP_W-1:0] dp_s3_ff;
   logic signed [IP_W-1:0] ip_s3_ff;

   // Stage 4 registers
   logic                  neg_s4_ff, big_s4_ff;
   logic [QUOT_IN_W-1:0]  mlo_s4_ff;

   // Stage 1 logic
   logic signed [OFFSET_W-1:0] e;
   logic [OFFSET_W-1:0]        e_abs;
   logic [MAG_W-1:0]           mag;
   logic                       dead;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [ISUM_W-1:0]   isum;
   logic signed [INTEG_W-1:0]  iclamp;

   // Negate the offset, saturating the most negative one
   always_comb begin
      e      = (offset == OFFSET_MIN) ? OFFSET_MAX : -offset;
      e_abs  = e[OFFSET_W-1] ? -e : e;
      mag    = e_abs[MAG_W-1:0];
      dead   = (mag < MAG_W'(dead_zone));
      diff   = {e[OFFSET_W-1], e} - {last_ff[OFFSET_W-1], last_ff};
      isum   = {integ_ff[INTEG_W-1], integ_ff} + ISUM_W'(e);
      if (isum > ILIM_POS) begin
         iclamp = ILIM_POS[INTEG_W-1:0];
      end else if (isum < ILIM_NEG) begin
         iclamp = ILIM_NEG[INTEG_W-1:0];
      end else begin
         iclamp = isum[INTEG_W-1:0];
      end
   end

   // Clear state in the deadband, else advance it
   always_comb begin
      integ_in = integ_ff;
      last_in  = last_ff;
      if (dead) begin
         integ_in = '0;
         last_in  = '0;
      end else begin
         last_in = e;
         if (gain_i != '0) begin
            integ_in = iclamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else if (ctl.ld_s2) begin
         integ_ff <= integ_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_s2) begin
         e_s2_ff     <= e;
         diff_s2_ff  <= diff;
         integ_s2_ff <= integ_in;
         use_d_s2_ff <= ~dead & (last_ff != '0);
         use_i_s2_ff <= ~dead & (gain_i != '0);
         dead_s2_ff  <= dead;
      end
   end

   // Gain products
   logic signed [PP_W-1:0] pp;
   logic signed [DP_W-1:0] dp;
   logic signed [IP_W-1:0] ip;

   always_comb begin
      pp = $signed({1'b0, gain_p}) * e_s2_ff;
      dp = $signed({1'b0, gain_d}) * diff_s2_ff;
      ip = $signed({1'b0, gain_i}) * integ_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_s3) begin
         pp_s3_ff <= dead_s2_ff  ? '0 : pp;
         dp_s3_ff <= use_d_s2_ff ? dp : '0;
         ip_s3_ff <= use_i_s2_ff ? ip : '0;
      end
   end

   // Sum and split into sign, saturation flag and low magnitude
   logic signed [SUM_W-1:0] acc;
   logic [SUM_W-1:0]        acc_mag;

   always_comb begin
      acc     = SUM_W'(pp_s3_ff) + SUM_W'(dp_s3_ff) + SUM_W'(ip_s3_ff);
      acc_mag = acc[SUM_W-1] ? -acc : acc;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_s4) begin
         neg_s4_ff <= acc[SUM_W-1];
         big_s4_ff <= (acc_mag >= THRESH_V);
         mlo_s4_ff <= acc_mag[QUOT_IN_W-1:0];
      end
   end

   // Divide by 100 toward zero, clamp, restore the sign
   logic [QP_W-1:0]  qprod;
   logic [OUT_W-1:0] qmag;

   always_comb begin
      qprod = QP_W'(mlo_s4_ff) * QP_W'(RECIP_V);
      qmag  = big_s4_ff ? OLIM_V : qprod[RECIP_SHIFT +: OUT_W];
   end

   assign axis_out = $signed(neg_s4_ff ? -qmag : qmag);

endmodule

[rtl/core/two_axis_tracking_pid.sv]
// Two-axis tracking PID. A request carries one frame's target offset (x, y);
// each request yields one result, and a new request is taken every cycle
// unless the result channel stalls. Pipeline: input register, three PID
// stages (error and integral update, gain products, sum with divide-by-100
// and clamp), and the result register where the stepper pulse table, the
// servo angle and the frame counter are updated. The integral and last error
// close their loop inside the first PID stage and the servo angle and frame
// counter inside the result stage, so back-to-back requests see the state
// left by the one before. Gains and the dead zone are to be written over the
// APB port by the user while no request is in flight, which is not enforced.
module two_axis_tracking_pid import tapid_pkg::*; #(
   parameter int INTEGRAL_LIMIT_X = INTEGRAL_LIMIT_X_DEF,
   parameter int INTEGRAL_LIMIT_Y = INTEGRAL_LIMIT_Y_DEF,
   parameter int OUTPUT_LIMIT_X   = OUTPUT_LIMIT_X_DEF,
   parameter int OUTPUT_LIMIT_Y   = OUTPUT_LIMIT_Y_DEF,
   parameter int PULSES_PER_TURN  = PULSES_PER_TURN_DEF,
   parameter int ZERO_PERIOD      = ZERO_PERIOD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tapid_req_if.sink             req_chan,
   tapid_rsp_if.source           rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DEG_W   = $clog2(OUTPUT_LIMIT_X + 1);
   localparam int FRAME_W = $clog2(ZERO_PERIOD + 1);
   localparam int SSUM_W  = OUT_W + 1;

   localparam logic [FRAME_W-1:0]       FRAME_LAST  = FRAME_W'(ZERO_PERIOD - 1);
   localparam logic signed [SSUM_W-1:0] SERVO_HI_V  = SSUM_W'(SERVO_HIGH);
   localparam logic signed [SSUM_W-1:0] SERVO_LO_V  = SSUM_W'(SERVO_LOW);

   tapid_cfg_type cfg;

   tapid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pipeline occupancy and flow control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic ld1, ld5;
   tapid_stage_ctl_type ctl;

   always_comb begin
      rdy5      = ~v5_ff | rsp_chan.ready;
      rdy4      = ~v4_ff | rdy5;
      rdy3      = ~v3_ff | rdy4;
      rdy2      = ~v2_ff | rdy3;
      rdy1      = ~v1_ff | rdy2;
      ld1       = req_chan.valid & rdy1;
      ctl.ld_s2 = v1_ff & rdy2;
      ctl.ld_s3 = v2_ff & rdy3;
      ctl.ld_s4 = v3_ff & rdy4;
      ld5       = v4_ff & rdy5;
      v1_in     = ld1       | (v1_ff & ~rdy2);
      v2_in     = ctl.ld_s2 | (v2_ff & ~rdy3);
      v3_in     = ctl.ld_s3 | (v3_ff & ~rdy4);
      v4_in     = ctl.ld_s4 | (v4_ff & ~rdy5);
      v5_in     = ld5       | (v5_ff & ~rsp_chan.ready);
   end

   assign req_chan.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // Input register
   logic signed [OFFSET_W-1:0] offset_x_ff, offset_y_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         offset_x_ff <= req_chan.offset_x;
         offset_y_ff <= req_chan.offset_y;
      end
   end

   // PID axes
   logic signed [OUT_W-1:0] out_x, out_y;

   tapid_axis #(
      .INTEGRAL_LIMIT (INTEGRAL_LIMIT_X),
      .OUTPUT_LIMIT   (OUTPUT_LIMIT_X)
   ) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .offset    (offset_x_ff),
      .gain_p    (cfg.gain_p_x),
      .gain_i    (cfg.gain_i_x),
      .gain_d    (cfg.gain_d_x),
      .dead_zone (cfg.dead_zone),
      .axis_out  (out_x)
   );

   tapid_axis #(
      .INTEGRAL_LIMIT (INTEGRAL_LIMIT_Y),
      .OUTPUT_LIMIT   (OUTPUT_LIMIT_Y)
   ) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .offset    (offset_y_ff),
      .gain_p    (cfg.gain_p_y),
      .gain_i    (cfg.gain_i_y),
      .gain_d    (cfg.gain_d_y),
      .dead_zone (cfg.dead_zone),
      .axis_out  (out_y)
   );

   // Pulse table indexed by degrees of the X output
   logic [PULSE_W-1:0] pulse_table [OUTPUT_LIMIT_X+1];

   for (genvar g = 0; g <= OUTPUT_LIMIT_X; g++) begin : g_pulse
      assign pulse_table[g] = PULSE_W'(pulse_count(g, PULSES_PER_TURN));
   end

   // Stepper move, servo angle and frame counter
   logic [OUT_W-1:0]          deg_x;
   logic [PULSE_W-1:0]        pulses;
   logic                      step_en;
   logic signed [SSUM_W-1:0]  servo_sum;
   logic [SERVO_W-1:0]        servo_ff, servo_in;
   logic [FRAME_W-1:0]        frame_ff, frame_in;
   logic                      zero_flag;

   always_comb begin
      deg_x     = out_x[OUT_W-1] ? -out_x : out_x;
      pulses    = pulse_table[deg_x[DEG_W-1:0]];
      step_en   = (pulses != '0);
      servo_sum = $signed(SSUM_W'(servo_ff)) + {out_y[OUT_W-1], out_y};
      if (servo_sum < SERVO_LO_V) begin
         servo_in = SERVO_W'(SERVO_LOW);
      end else if (servo_sum > SERVO_HI_V) begin
         servo_in = SERVO_W'(SERVO_HIGH);
      end else begin
         servo_in = servo_sum[SERVO_W-1:0];
      end
      zero_flag = (frame_ff == FRAME_LAST);
      frame_in  = zero_flag ? '0 : frame_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_ff <= SERVO_W'(SERVO_CENTER);
         frame_ff <= '0;
      end else if (ld5) begin
         servo_ff <= servo_in;
         frame_ff <= frame_in;
      end
   end

   // Result register
   logic               step_enable_ff, step_dir_ff, zero_position_ff;
   logic [PULSE_W-1:0] step_pulses_ff;
   logic [SERVO_W-1:0] servo_setting_ff;

   always_ff @(posedge clock) begin
      if (ld5) begin
         step_enable_ff   <= step_en;
         step_dir_ff      <= step_en & out_x[OUT_W-1];
         step_pulses_ff   <= pulses;
         servo_setting_ff <= servo_in;
         zero_position_ff <= zero_flag;
      end
   end

   assign rsp_chan.valid         = v5_ff;
   assign rsp_chan.step_enable   = step_enable_ff;
   assign rsp_chan.step_dir      = step_dir_ff;
   assign rsp_chan.step_pulses   = step_pulses_ff;
   assign rsp_chan.servo_setting = servo_setting_ff;
   assign rsp_chan.zero_position = zero_position_ff;

`ifndef NO_ASSERTIONS
   // Servo angle stays in its travel
   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.servo_setting <= SERVO_W'(SERVO_HIGH))
      else $error("servo angle out of range");

   // A result without a move carries no direction and no pulses
   a_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.step_enable |->
         !rsp_chan.step_dir && rsp_chan.step_pulses == '0)
      else $error("idle move carries direction or pulses");

   // Frame counter stays below the zeroing period
   a_frame_range: assert property (@(posedge clock) disable iff (reset)
      frame_ff <= FRAME_LAST)
      else $error("frame counter past period");

   // A zeroing result wraps the frame counter
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      ld5 && zero_flag |=> frame_ff == '0 && rsp_chan.zero_position)
      else $error("zeroing result without counter wrap");

   // Nothing leaves the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");
`endif

endmodule
